FILE: design/pee_pkg.sv
`default_nettype none

package pee_pkg;

    localparam int DATA_W    = 32;
    localparam int SYM_W     = 8;
    localparam int DIV_STEPS = 32;

    localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_code_t;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic         capture;
        logic         push;
        logic         alu;
        logic         div_start;
        logic         div_write;
        logic         set_err;
        status_code_t err_code;
        logic         emit;
    } dp_cmd_t;

    // flags from datapath to controller
    typedef struct packed {
        logic is_op;
        logic is_div;
        logic err_set;
        logic last;
        logic full;
        logic lt2;
        logic rhs_zero;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/pee_divider.sv
`default_nettype none

module pee_divider
    import pee_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic      [DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [DATA_W-1:0] rem_reg,  rem_next;
    logic [DATA_W-1:0] quo_reg,  quo_next;
    logic [DATA_W-1:0] dvs_reg,  dvs_next;
    logic              neg_reg,  neg_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;

    // one quotient bit per cycle, restoring form
    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            dvs_next = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            neg_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (run_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

FILE: design/pee_datapath.sv
`default_nettype none

module pee_datapath
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 128
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire dp_cmd_t                  cmd,
    output dp_stat_t                      flags,
    input  wire logic [SYM_W-1:0]         symbol,
    input  wire logic                     last_symbol,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      result_value,
    output logic        [1:0]             status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // entries below the top word; the top word lives in tos_reg
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

    logic [SYM_W-1:0]   sym_reg;
    logic               last_reg;
    logic [DATA_W-1:0]  tos_reg;
    logic [DATA_W-1:0]  rd_reg;
    logic [CW-1:0]      count_reg, count_next;
    status_code_t       err_reg,   err_next;
    logic               oval_reg,  oval_next;
    logic [DATA_W-1:0]  oval_data_reg;
    status_code_t       ostat_reg;

    logic [CW-1:0]      cnt_m1;
    logic [CW-1:0]      cnt_m2;
    op_t                op;
    logic [DATA_W-1:0]  alu_res;
    logic [DATA_W-1:0]  push_val;
    logic               div_done;
    logic [DATA_W-1:0]  div_q;
    logic               out_free;

    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);

    always_comb
    begin
        case (sym_reg)
            CHAR_PLUS:  op = OP_ADD;
            CHAR_MINUS: op = OP_SUB;
            CHAR_STAR:  op = OP_MUL;
            CHAR_SLASH: op = OP_DIV;
            default:    op = OP_PUSH;
        endcase
    end

    always_comb
    begin
        case (op)
            OP_SUB:  alu_res = rd_reg - tos_reg;
            OP_MUL:  alu_res = DATA_W'(rd_reg * tos_reg);
            default: alu_res = rd_reg + tos_reg;
        endcase
    end

    assign push_val = DATA_W'(sym_reg) - DATA_W'(CHAR_ZERO);

    pee_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free = !oval_reg || out_ready;

    always_comb
    begin
        flags.is_op    = (op != OP_PUSH);
        flags.is_div   = (op == OP_DIV);
        flags.err_set  = (err_reg != ST_OK);
        flags.last     = last_reg;
        flags.full     = (count_reg == CW'(STACK_DEPTH));
        flags.lt2      = (count_reg < CW'(2));
        flags.rhs_zero = (tos_reg == '0);
        flags.div_done = div_done;
        flags.out_free = out_free;
    end

    always_comb
    begin
        count_next = count_reg;
        err_next   = err_reg;
        oval_next  = oval_reg && !out_ready;
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.alu || cmd.div_write)
        begin
            count_next = cnt_m1;
        end
        if (cmd.set_err)
        begin
            err_next = cmd.err_code;
        end
        if (cmd.emit)
        begin
            count_next = '0;
            err_next   = ST_OK;
            oval_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            err_reg   <= ST_OK;
            oval_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sym_reg  <= symbol;
            last_reg <= last_symbol;
        end
        if (cmd.push)
        begin
            tos_reg <= push_val;
        end
        else if (cmd.alu)
        begin
            tos_reg <= alu_res;
        end
        else if (cmd.div_write)
        begin
            tos_reg <= div_q;
        end
        if (cmd.emit)
        begin
            if (err_reg != ST_OK)
            begin
                oval_data_reg <= '0;
                ostat_reg     <= err_reg;
            end
            else if (count_reg == '0)
            begin
                oval_data_reg <= '0;
                ostat_reg     <= ST_UNDERFLOW;
            end
            else
            begin
                oval_data_reg <= tos_reg;
                ostat_reg     <= ST_OK;
            end
        end
    end

    // second entry from the top is fetched every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push && (count_reg != '0))
        begin
            stack_mem[cnt_m1[AW-1:0]] <= tos_reg;
        end
        rd_reg <= stack_mem[cnt_m2[AW-1:0]];
    end

    assign out_valid    = oval_reg;
    assign result_value = oval_data_reg;
    assign status       = ostat_reg;

endmodule

`default_nettype wire

FILE: design/pee_ctrl.sv
`default_nettype none

module pee_ctrl
    import pee_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t flags,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!flags.err_set && flags.is_div && !flags.lt2 && !flags.rhs_zero)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = flags.last ? S_EMIT : S_IDLE;
                end
            end
            S_DIV:
            begin
                if (flags.div_done)
                begin
                    state_next = flags.last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (flags.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.err_code = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                if (!flags.err_set)
                begin
                    if (!flags.is_op)
                    begin
                        if (flags.full)
                        begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = ST_OVERFLOW;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    else if (flags.lt2)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_UNDERFLOW;
                    end
                    else if (flags.is_div)
                    begin
                        if (flags.rhs_zero)
                        begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = ST_DIVZERO;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.alu = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_write = flags.div_done;
            end
            S_EMIT:
            begin
                cmd.emit = flags.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/postfix_expression_evaluator_top.sv
// postfix evaluator: one expression character per input word, the final character flagged by
// last_symbol; digits and any byte other than + - * / push (byte - 48), operators pop two and
// push the 32-bit wrapping result, and the flagged word yields one output word carrying the top
// of stack and a status (0 ok, 1 overflow, 2 underflow, 3 divide by zero; value 0 on error).
// an operand or + - * word is accepted in the idle state and then executed; a divide
// then waits in the divide state on the 32-step restoring divider; the flagged word then
// hands its result to the output register in the emit state, and waits there while an earlier
// result is still untaken. after an error the rest of the expression is swallowed word by word.

`default_nettype none

module postfix_expression_evaluator_top
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 128
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // input words
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [SYM_W-1:0]         symbol,
    input  wire logic                     last_symbol,
    // result words
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      result_value,
    output logic        [1:0]             status
);

    // controller to datapath commands and returning flags
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_flags;

    pee_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .flags    (dp_flags),
        .cmd      (dp_cmd)
    );

    // stack memory, top-of-stack register, divider and output register
    pee_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .flags        (dp_flags),
        .symbol       (symbol),
        .last_symbol  (last_symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status)
    );

    // a word is executed before the next is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous word still executing");

    // an error result never carries a value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (result_value == '0))
        else $error("error result with non-zero value");

    // results appear only from the emit step, never while accepting
    a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised outside the emit step");

endmodule

`default_nettype wire
